@@ design/kht_pkg.sv @@
// Shared types, field widths, opcodes and status codes for the keyed hash table engine.
// No dependencies; every other design file but kht_ram refers to this package by scoped names.
package kht_pkg;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 64;
    localparam int VAL_W    = 64;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    localparam int DEF_NUM_BUCKETS     = 256;
    localparam int DEF_WAYS_PER_BUCKET = 4;

    // Key bits folded into the bucket remainder per cycle (non power-of-two bucket count)
    localparam int HASH_STEP_BITS = 4;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_GET    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERWRITTEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL        = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value_in;
    } kht_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    value_out;
        logic [COUNT_W-1:0]  element_count;
    } kht_rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic rd_input;
        logic hash_start;
        logic hash_step;
        logic rd_hash;
        logic commit;
    } kht_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic direct_hash;
        logic clear_last;
        logic hash_done;
    } kht_status_t;

endpackage

@@ design/kht_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/kht_ctrl.sv @@
// Sequencing state machine of the keyed hash table engine: clear pass, accept,
// bucket hash, lookup and commit. Uses kht_pkg command and status types.
module kht_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output kht_pkg::kht_cmd_t    cmd,
    input  kht_pkg::kht_status_t stat
);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_HASH   = 2'd2;
    localparam logic [1:0] S_LOOKUP = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       accept;
    logic       slot_free;
    logic       commit;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign commit    = (state_reg == S_LOOKUP) && slot_free;

    always_comb
    begin
        cmd            = '0;
        cmd.clear_step = (state_reg == S_CLEAR);
        cmd.capture    = accept;
        cmd.rd_input   = accept && stat.direct_hash;
        cmd.hash_start = accept && !stat.direct_hash;
        cmd.hash_step  = (state_reg == S_HASH) && !stat.hash_done;
        cmd.rd_hash    = (state_reg == S_HASH) && stat.hash_done;
        cmd.commit     = commit;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = stat.direct_hash ? S_LOOKUP : S_HASH;
                end
            end
            S_HASH:
            begin
                if (stat.hash_done)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

@@ design/kht_dp.sv @@
// Datapath of the keyed hash table engine: request register, bucket hash,
// bucket RAM, way compare, row update, element count and result register.
// Depends on kht_pkg and kht_ram.
module kht_dp #(
    parameter int NUM_BUCKETS     = kht_pkg::DEF_NUM_BUCKETS,
    parameter int WAYS_PER_BUCKET = kht_pkg::DEF_WAYS_PER_BUCKET
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kht_pkg::kht_cmd_t     cmd,
    output kht_pkg::kht_status_t  stat,
    input  kht_pkg::kht_req_t     req_data,
    output kht_pkg::kht_rsp_t     rsp_data
);

    localparam int KEY_W      = kht_pkg::KEY_W;
    localparam int VAL_W      = kht_pkg::VAL_W;
    localparam int WAYS       = WAYS_PER_BUCKET;
    localparam int BUCKET_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int ROW_W      = WAYS + WAYS * KEY_W + WAYS * VAL_W;
    localparam int TOTAL_WAYS = NUM_BUCKETS * WAYS;
    localparam int CNT_W      = $clog2(TOTAL_WAYS + 1);
    localparam bit DIRECT     = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);

    kht_pkg::kht_req_t   req_reg;
    kht_pkg::kht_rsp_t   rsp_reg;
    kht_pkg::kht_rsp_t   rsp_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [BUCKET_W-1:0] clear_addr_reg;
    logic [BUCKET_W-1:0] lookup_bucket;
    logic [BUCKET_W-1:0] rd_addr;
    logic [BUCKET_W-1:0] wr_addr;
    logic                rd_en;
    logic                wr_en;
    logic [ROW_W-1:0]    rd_row;
    logic [ROW_W-1:0]    new_row;
    logic [ROW_W-1:0]    wr_row;
    logic                hash_done;

    logic [WAYS-1:0]     rd_valid;
    logic [KEY_W-1:0]    rd_key [WAYS];
    logic [VAL_W-1:0]    rd_val [WAYS];
    logic [WAYS-1:0]     hit_oh;
    logic [WAYS-1:0]     free_oh;
    logic                hit;
    logic                has_free;
    logic [VAL_W-1:0]    hit_val;

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req_data;
        end
    end

    // Bucket index: a mask for power-of-two bucket counts, otherwise a
    // remainder folded in a few key bits per cycle, most significant first.
    generate
        if (DIRECT)
        begin : g_direct
            assign lookup_bucket = BUCKET_W'(req_reg.key & KEY_W'(NUM_BUCKETS - 1));
            assign rd_addr       = cmd.rd_input ?
                                   BUCKET_W'(req_data.key & KEY_W'(NUM_BUCKETS - 1)) :
                                   lookup_bucket;
            assign hash_done     = 1'b1;
        end
        else
        begin : g_remainder
            localparam int STEP      = kht_pkg::HASH_STEP_BITS;
            localparam int HASH_CYC  = KEY_W / STEP;
            localparam int HCNT_W    = $clog2(HASH_CYC + 1);
            localparam logic [BUCKET_W:0] MODULUS = (BUCKET_W + 1)'(NUM_BUCKETS);

            logic [BUCKET_W-1:0] rem_reg;
            logic [BUCKET_W-1:0] rem_next;
            logic [KEY_W-1:0]    shift_reg;
            logic [HCNT_W-1:0]   hcnt_reg;

            always_comb
            begin
                logic [BUCKET_W:0] t;
                rem_next = rem_reg;
                for (int s = 0; s < STEP; s++)
                begin
                    t = {rem_next, shift_reg[KEY_W-1-s]};
                    if (t >= MODULUS)
                    begin
                        t = t - MODULUS;
                    end
                    rem_next = t[BUCKET_W-1:0];
                end
            end

            always_ff @(posedge clk)
            begin
                if (cmd.hash_start)
                begin
                    rem_reg   <= '0;
                    shift_reg <= req_data.key;
                end
                else if (cmd.hash_step)
                begin
                    rem_reg   <= rem_next;
                    shift_reg <= shift_reg << STEP;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    hcnt_reg <= '0;
                end
                else if (cmd.hash_start)
                begin
                    hcnt_reg <= '0;
                end
                else if (cmd.hash_step)
                begin
                    hcnt_reg <= hcnt_reg + HCNT_W'(1);
                end
            end

            assign hash_done     = (hcnt_reg == HCNT_W'(HASH_CYC));
            assign lookup_bucket = rem_reg;
            assign rd_addr       = rem_reg;
        end
    endgenerate

    // Clear pass address after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clear_addr_reg <= clear_addr_reg + BUCKET_W'(1);
        end
    end

    assign stat.direct_hash = DIRECT;
    assign stat.clear_last  = (clear_addr_reg == BUCKET_W'(NUM_BUCKETS - 1));
    assign stat.hash_done   = hash_done;

    assign rd_en   = cmd.rd_input || cmd.rd_hash;
    assign wr_en   = cmd.clear_step || cmd.commit;
    assign wr_addr = cmd.clear_step ? clear_addr_reg : lookup_bucket;
    assign wr_row  = cmd.clear_step ? '0 : new_row;

    kht_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_BUCKETS)
    ) u_bucket_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_row),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_row)
    );

    // Split the row and compare all ways
    always_comb
    begin
        logic found_hit;
        logic found_free;
        found_hit  = 1'b0;
        found_free = 1'b0;
        hit_oh     = '0;
        free_oh    = '0;
        hit_val    = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            rd_valid[w] = rd_row[w];
            rd_key[w]   = rd_row[WAYS + w * KEY_W +: KEY_W];
            rd_val[w]   = rd_row[WAYS + WAYS * KEY_W + w * VAL_W +: VAL_W];
            if (rd_valid[w])
            begin
                if (!found_hit && (rd_key[w] == req_reg.key))
                begin
                    found_hit = 1'b1;
                    hit_oh[w] = 1'b1;
                    hit_val   = rd_val[w];
                end
            end
            else if (!found_free)
            begin
                found_free = 1'b1;
                free_oh[w] = 1'b1;
            end
        end
        hit      = found_hit;
        has_free = found_free;
    end

    // Row update, status and count
    always_comb
    begin
        logic [WAYS-1:0]  nv;
        logic             do_ins_hit;
        logic             do_ins_new;
        logic             do_remove;
        nv                 = rd_valid;
        do_ins_hit         = 1'b0;
        do_ins_new         = 1'b0;
        do_remove          = 1'b0;
        count_next         = count_reg;
        rsp_next.status    = kht_pkg::ST_OK;
        rsp_next.value_out = '0;
        case (req_reg.opcode)
            kht_pkg::OP_INSERT:
            begin
                if (hit)
                begin
                    do_ins_hit      = 1'b1;
                    rsp_next.status = kht_pkg::ST_OVERWRITTEN;
                end
                else if (has_free)
                begin
                    do_ins_new = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    rsp_next.status = kht_pkg::ST_FULL;
                end
            end
            kht_pkg::OP_REMOVE:
            begin
                if (hit)
                begin
                    do_remove = 1'b1;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    rsp_next.status = kht_pkg::ST_NOT_FOUND;
                end
            end
            kht_pkg::OP_GET:
            begin
                if (hit)
                begin
                    rsp_next.value_out = hit_val;
                end
                else
                begin
                    rsp_next.status = kht_pkg::ST_NOT_FOUND;
                end
            end
            default:
            begin
                // Unused opcode: no change
            end
        endcase
        rsp_next.element_count = kht_pkg::COUNT_W'(count_next);

        new_row = rd_row;
        for (int w = 0; w < WAYS; w++)
        begin
            if (do_ins_new && free_oh[w])
            begin
                nv[w] = 1'b1;
                new_row[WAYS + w * KEY_W +: KEY_W] = req_reg.key;
            end
            if (do_remove && hit_oh[w])
            begin
                nv[w] = 1'b0;
            end
            if ((do_ins_hit && hit_oh[w]) || (do_ins_new && free_oh[w]))
            begin
                new_row[WAYS + WAYS * KEY_W + w * VAL_W +: VAL_W] = req_reg.value_in;
            end
        end
        new_row[WAYS-1:0] = nv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_data = rsp_reg;

endmodule

@@ design/keyed_hash_table_engine_top.sv @@
// Top level of the keyed hash table engine: controller plus datapath.
// Depends on kht_pkg, kht_ctrl, kht_dp (and kht_ram through kht_dp).
//
// Usage:
//   Request channel (req_valid / req_ready / req_data) carries one insert,
//   remove or get per transfer; response channel (rsp_valid / rsp_ready /
//   rsp_data) returns exactly one result per request, in order.
//   Each bucket is one RAM row holding all its ways (valid, key, value). A
//   request reads its bucket row, then compares every way in parallel and,
//   when the result slot is free, writes back the row and the result register.
//   Power-of-two bucket count: the bucket is the low key bits and its row is
//   read as the request is taken. Other bucket counts: the bucket remainder
//   is first folded 4 key bits per cycle and the row is read once that ends.
//   A new request is taken only after the previous one has been written back.
//   Reset: a clearing pass writes every bucket row with all ways invalid, one
//   row per cycle; req_ready stays low until it ends. The element count
//   resets to zero.
//   Stall: a held result does not block the next request transfer; that
//   request waits at its write-back until the held result has been taken.
module keyed_hash_table_engine_top #(
    parameter int NUM_BUCKETS     = kht_pkg::DEF_NUM_BUCKETS,
    parameter int WAYS_PER_BUCKET = kht_pkg::DEF_WAYS_PER_BUCKET
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  kht_pkg::kht_req_t req_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output kht_pkg::kht_rsp_t rsp_data
);

    // Command and status between the controller and the datapath
    kht_pkg::kht_cmd_t    cmd;
    kht_pkg::kht_status_t stat;

    // Sequence: clear pass, accept, hash (if needed), lookup, commit
    kht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Hold the request, the bucket RAM, the count and the result register
    kht_dp #(
        .NUM_BUCKETS     (NUM_BUCKETS),
        .WAYS_PER_BUCKET (WAYS_PER_BUCKET)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .req_data (req_data),
        .rsp_data (rsp_data)
    );

endmodule
